// ----- hdl/bpsm_pkg.sv -----
package bpsm_pkg;

  localparam int unsigned ADC_W     = 12;
  localparam int unsigned RATIO_W   = 4;
  localparam int unsigned MV_W      = 16;
  localparam int unsigned TICK_W    = 32;
  localparam int unsigned PCT_W     = 7;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 32;
  localparam int unsigned LEVELS    = 10;
  localparam int unsigned LEVEL_CNT_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_DIVIDER_RATIO     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSE_ENABLED     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_VOLTAGE_MV    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_TIMEOUT_TICKS = 8'd3;

  localparam logic [RATIO_W-1:0] RATIO_RESET   = 4'd2;
  localparam logic               SENSE_RESET   = 1'b1;
  localparam logic [MV_W-1:0]    LOW_MV_RESET  = 16'd3200;
  localparam logic [TICK_W-1:0]  TIMEOUT_RESET = 32'd5000;
  localparam logic [MV_W-1:0]    MINMAX_RESET  = 16'd3700;

  localparam logic [MV_W-1:0] LEVEL_MV [LEVELS] = '{
    16'd3000, 16'd3780, 16'd3830, 16'd3870, 16'd3890,
    16'd3920, 16'd3960, 16'd4000, 16'd4040, 16'd4100
  };

  typedef enum logic [1:0] {
    PS_CHARGED  = 2'd0,
    PS_CHARGING = 2'd1,
    PS_LOW      = 2'd2,
    PS_BATTERY  = 2'd3
  } power_state_t;

  typedef struct packed {
    logic [RATIO_W-1:0] divider_ratio;
    logic               sense_enabled;
    logic [MV_W-1:0]    low_voltage_mv;
    logic [TICK_W-1:0]  low_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [ADC_W-1:0]  adc_mv;
    logic              power_good;
    logic              charging;
    logic [TICK_W-1:0] now_ticks;
  } sample_t;

  typedef struct packed {
    power_state_t      power_state;
    logic              state_changed;
    logic              can_fly;
    logic [PCT_W-1:0]  charge_percent;
    logic [MV_W-1:0]   voltage_mv;
    logic [MV_W-1:0]   min_mv;
    logic [MV_W-1:0]   max_mv;
  } result_t;

  function automatic logic [PCT_W-1:0] level_percent(input logic [LEVEL_CNT_W-1:0] n);
    logic [PCT_W-1:0] p;
    unique case (n)
      4'd0:    p = 7'd0;
      4'd1:    p = 7'd10;
      4'd2:    p = 7'd20;
      4'd3:    p = 7'd30;
      4'd4:    p = 7'd40;
      4'd5:    p = 7'd50;
      4'd6:    p = 7'd60;
      4'd7:    p = 7'd70;
      4'd8:    p = 7'd80;
      default: p = 7'd90;
    endcase
    return p;
  endfunction

endpackage

// ----- hdl/bpsm_cfg.sv -----
module bpsm_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bpsm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpsm_pkg::CFG_DAT_W-1:0]  cfg_data,
  output bpsm_pkg::cfg_t                  cfg
);
  import bpsm_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.divider_ratio     <= RATIO_RESET;
      cfg.sense_enabled     <= SENSE_RESET;
      cfg.low_voltage_mv    <= LOW_MV_RESET;
      cfg.low_timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DIVIDER_RATIO:     cfg.divider_ratio     <= cfg_data[RATIO_W-1:0];
        CFG_SENSE_ENABLED:     cfg.sense_enabled     <= cfg_data[0];
        CFG_LOW_VOLTAGE_MV:    cfg.low_voltage_mv    <= cfg_data[MV_W-1:0];
        CFG_LOW_TIMEOUT_TICKS: cfg.low_timeout_ticks <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- hdl/bpsm_eval.sv -----
module bpsm_eval (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  bpsm_pkg::cfg_t    cfg,
  input  bpsm_pkg::sample_t sample,
  output bpsm_pkg::result_t result
);
  import bpsm_pkg::*;

  logic [MV_W-1:0]        voltage_min, voltage_min_next;
  logic [MV_W-1:0]        voltage_max, voltage_max_next;
  logic [TICK_W-1:0]      low_stamp, low_stamp_next;
  power_state_t           previous_state, state_next;
  logic [MV_W-1:0]        mv;
  logic [TICK_W-1:0]      elapsed;
  logic [LEVELS-1:0]      above;
  logic [LEVEL_CNT_W-1:0] n;

  always_comb begin
    mv = cfg.sense_enabled ? MV_W'(sample.adc_mv * cfg.divider_ratio) : '0;
    voltage_max_next = (voltage_max < mv) ? mv : voltage_max;
    voltage_min_next = (voltage_min > mv) ? mv : voltage_min;
    low_stamp_next   = (mv > cfg.low_voltage_mv) ? sample.now_ticks : low_stamp;
    elapsed          = sample.now_ticks - low_stamp_next;

    priority if (sample.power_good && !sample.charging)
      state_next = PS_CHARGED;
    else if (sample.power_good)
      state_next = PS_CHARGING;
    else if (!sample.charging && elapsed > cfg.low_timeout_ticks)
      state_next = PS_LOW;
    else
      state_next = PS_BATTERY;

    for (int i = 0; i < LEVELS; i++) begin
      above[i] = mv > LEVEL_MV[i];
    end
    n = LEVEL_CNT_W'($countones(above));

    result.power_state    = state_next;
    result.state_changed  = state_next != previous_state;
    result.can_fly        = !(state_next == PS_CHARGED || state_next == PS_CHARGING);
    result.charge_percent = level_percent(n);
    result.voltage_mv     = mv;
    result.min_mv         = voltage_min_next;
    result.max_mv         = voltage_max_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      voltage_min    <= MINMAX_RESET;
      voltage_max    <= MINMAX_RESET;
      low_stamp      <= '0;
      previous_state <= PS_BATTERY;
    end else if (advance) begin
      voltage_min    <= voltage_min_next;
      voltage_max    <= voltage_max_next;
      low_stamp      <= low_stamp_next;
      previous_state <= state_next;
    end
  end

endmodule

// ----- hdl/battery_power_state_monitor_core.sv -----
// Battery power state monitor. Each sample transfer (ADC pin mV, charger flags, tick count)
// yields one result: scaled voltage, running min and max, charge percent in tens, power
// state with a change flag, and can_fly. A sample is registered on input, evaluated
// combinationally and written into the result register; a new sample can be taken every
// cycle while the result side is not stalled. Tracking state advances only as
// results are written, so stalls on the result side hold everything in order.
// Configuration writes are taken at any time but are meant for when the block is idle.
module battery_power_state_monitor_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bpsm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpsm_pkg::CFG_DAT_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [bpsm_pkg::ADC_W-1:0]      adc_mv,
  input  logic                            power_good,
  input  logic                            charging,
  input  logic [bpsm_pkg::TICK_W-1:0]     now_ticks,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      power_state,
  output logic                            state_changed,
  output logic                            can_fly,
  output logic [bpsm_pkg::PCT_W-1:0]      charge_percent,
  output logic [bpsm_pkg::MV_W-1:0]       voltage_mv,
  output logic [bpsm_pkg::MV_W-1:0]       min_mv,
  output logic [bpsm_pkg::MV_W-1:0]       max_mv
);
  import bpsm_pkg::*;

  cfg_t    cfg;
  sample_t sample;
  logic    sample_valid;
  logic    advance;
  result_t result_next;
  result_t result;

  bpsm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign advance  = sample_valid && (!out_valid || out_ready);
  assign in_ready = !sample_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (in_ready) begin
      sample_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample.adc_mv     <= adc_mv;
      sample.power_good <= power_good;
      sample.charging   <= charging;
      sample.now_ticks  <= now_ticks;
    end
  end

  bpsm_eval u_eval (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .cfg     (cfg),
    .sample  (sample),
    .result  (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign power_state    = result.power_state;
  assign state_changed  = result.state_changed;
  assign can_fly        = result.can_fly;
  assign charge_percent = result.charge_percent;
  assign voltage_mv     = result.voltage_mv;
  assign min_mv         = result.min_mv;
  assign max_mv         = result.max_mv;

endmodule

// ----- tb/tb_battery_power_state_monitor_core.sv -----
module tb_battery_power_state_monitor_core;
  timeunit 1ns;
  timeprecision 1ps;

  import bpsm_pkg::*;

  localparam int unsigned STALL_LIMIT = 3000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [ADC_W-1:0]     adc_mv = '0;
  logic                 power_good = 1'b0;
  logic                 charging = 1'b0;
  logic [TICK_W-1:0]    now_ticks = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           power_state;
  logic                 state_changed;
  logic                 can_fly;
  logic [PCT_W-1:0]     charge_percent;
  logic [MV_W-1:0]      voltage_mv;
  logic [MV_W-1:0]      min_mv;
  logic [MV_W-1:0]      max_mv;

  battery_power_state_monitor_core dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .adc_mv         (adc_mv),
    .power_good     (power_good),
    .charging       (charging),
    .now_ticks      (now_ticks),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .power_state    (power_state),
    .state_changed  (state_changed),
    .can_fly        (can_fly),
    .charge_percent (charge_percent),
    .voltage_mv     (voltage_mv),
    .min_mv         (min_mv),
    .max_mv         (max_mv)
  );

  always #5 clk = ~clk;

  // register copies and tracking state
  logic [RATIO_W-1:0] cfg_ratio = RATIO_RESET;
  logic               cfg_sense = SENSE_RESET;
  logic [MV_W-1:0]    cfg_low_mv = LOW_MV_RESET;
  logic [TICK_W-1:0]  cfg_timeout = TIMEOUT_RESET;
  logic [MV_W-1:0]    track_min = MINMAX_RESET;
  logic [MV_W-1:0]    track_max = MINMAX_RESET;
  logic [TICK_W-1:0]  last_above_tick = '0;
  power_state_t       last_state = PS_BATTERY;

  sample_t     samples_to_send[$];
  result_t     pending_reports[$];
  sample_t     offered;
  logic [31:0] tick_now = '0;
  bit          calm = 1'b0;
  int          gap_left = 0;
  int          stall_left = 0;
  int          mismatches = 0;
  int          reports_seen = 0;
  int          idle_cycles = 0;

  function automatic result_t eval_sample(input sample_t s);
    result_t      r;
    logic [31:0]  prod;
    logic [MV_W-1:0] mv;
    logic [31:0]  elapsed;
    power_state_t st;
    int           n;
    prod = s.adc_mv * cfg_ratio;
    mv = cfg_sense ? prod[MV_W-1:0] : '0;
    if (track_max < mv) track_max = mv;
    if (track_min > mv) track_min = mv;
    if (mv > cfg_low_mv) last_above_tick = s.now_ticks;
    elapsed = s.now_ticks - last_above_tick;
    if (s.power_good && !s.charging) st = PS_CHARGED;
    else if (s.power_good && s.charging) st = PS_CHARGING;
    else if (!s.power_good && !s.charging && elapsed > cfg_timeout) st = PS_LOW;
    else st = PS_BATTERY;
    n = 0;
    if (mv >= LEVEL_MV[0]) begin
      for (int i = 0; i < LEVELS; i++) begin
        if (mv > LEVEL_MV[i]) n++;
      end
    end
    if (n > 9) n = 9;
    r.power_state    = st;
    r.state_changed  = (st != last_state);
    r.can_fly        = !(st == PS_CHARGED || st == PS_CHARGING);
    r.charge_percent = PCT_W'(n * 10);
    r.voltage_mv     = mv;
    r.min_mv         = track_min;
    r.max_mv         = track_max;
    last_state = st;
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [ADC_W-1:0] adc_for(input int mv);
    int a;
    if (cfg_ratio == 0) a = $urandom_range(0, 4095);
    else if (mv <= 0) a = 0;
    else a = mv / int'(cfg_ratio);
    if (a > 4095) a = 4095;
    return ADC_W'(a);
  endfunction

  task automatic queue_sample(input logic [ADC_W-1:0] adc, input logic pg, input logic chg,
                              input logic [TICK_W-1:0] now);
    sample_t s;
    s.adc_mv     = adc;
    s.power_good = pg;
    s.charging   = chg;
    s.now_ticks  = now;
    samples_to_send.push_back(s);
  endtask

  // mostly coherent discharge and charge runs, with some noise and broken runs
  task automatic queue_phase(input int unsigned count);
    int unsigned made;
    int unsigned kind;
    int unsigned mode;
    int unsigned run_len;
    int          mv;
    int          drift;
    logic        pg;
    logic        chg;
    logic [31:0] step_max;
    made = 0;
    while (made < count) begin
      kind = $urandom_range(0, 99);
      mode = $urandom_range(0, 99);
      run_len = $urandom_range(4, 16);
      step_max = (cfg_timeout > 32'h4000_0000) ? 32'h4000_0000 : cfg_timeout / 3 + 2;
      case ($urandom_range(0, 3))
        0, 1:    mv = $urandom_range(2900, 4200);
        2:       mv = int'(cfg_low_mv) + $urandom_range(0, 400) - 200;
        default: mv = $urandom_range(0, 61425);
      endcase
      drift = $urandom_range(0, 60) - 30;
      for (int i = 0; i < run_len && made < count; i++) begin
        if (kind < 12) begin
          queue_sample(ADC_W'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), $urandom);
        end else begin
          if (kind < 24) begin
            pg = i[0];
            chg = 1'($urandom_range(0, 1));
            tick_now -= $urandom_range(0, step_max);
          end else begin
            if (mode < 55) {pg, chg} = 2'b00;
            else if (mode < 70) {pg, chg} = 2'b11;
            else if (mode < 85) {pg, chg} = 2'b10;
            else {pg, chg} = 2'($urandom_range(0, 3));
            tick_now += $urandom_range(0, step_max);
          end
          queue_sample(adc_for(mv), pg, chg, tick_now);
          mv += drift + $urandom_range(0, 20) - 10;
        end
        made++;
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_DIVIDER_RATIO:     cfg_ratio = val[RATIO_W-1:0];
      CFG_SENSE_ENABLED:     cfg_sense = val[0];
      CFG_LOW_VOLTAGE_MV:    cfg_low_mv = val[MV_W-1:0];
      CFG_LOW_TIMEOUT_TICKS: cfg_timeout = val[TICK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (samples_to_send.size() != 0 || in_valid || pending_reports.size() != 0);
  endtask

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        pending_reports.push_back(eval_sample(offered));
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (samples_to_send.size() > 0) begin
          offered = samples_to_send.pop_front();
          adc_mv     <= offered.adc_mv;
          power_good <= offered.power_good;
          charging   <= offered.charging;
          now_ticks  <= offered.now_ticks;
          in_valid   <= 1'b1;
          gap_left = calm ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        got.power_state    = power_state_t'(power_state);
        got.state_changed  = state_changed;
        got.can_fly        = can_fly;
        got.charge_percent = charge_percent;
        got.voltage_mv     = voltage_mv;
        got.min_mv         = min_mv;
        got.max_mv         = max_mv;
        if (pending_reports.size() == 0) begin
          if (mismatches < 10) $display("report %0d arrived with nothing awaited", reports_seen);
          mismatches++;
        end else begin
          want = pending_reports.pop_front();
          if (got !== want) begin
            if (mismatches < 10) begin
              $display("report %0d mismatch", reports_seen);
              $display("  expected state %0d chg %0b fly %0b pct %0d mv %0d min %0d max %0d",
                       want.power_state, want.state_changed, want.can_fly,
                       want.charge_percent, want.voltage_mv, want.min_mv, want.max_mv);
              $display("  actual   state %0d chg %0b fly %0b pct %0d mv %0d min %0d max %0d",
                       got.power_state, got.state_changed, got.can_fly,
                       got.charge_percent, got.voltage_mv, got.min_mv, got.max_mv);
            end
            mismatches++;
          end
        end
        reports_seen++;
        // long hold-off so the block backs up
        if (reports_seen == 150 || reports_seen == 450) stall_left = 200;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 20) begin
        stall_left = pick_gap();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    int unsigned       phase;
    logic [RATIO_W-1:0] new_ratio;
    logic               new_sense;
    logic [MV_W-1:0]    new_low;
    logic [TICK_W-1:0]  new_timeout;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // register reset values: edges of the fields, thresholds, low timer and tick wrap
    @(negedge clk);
    queue_sample(12'd0,    1'b0, 1'b0, 32'd0);
    queue_sample(12'd4095, 1'b1, 1'b1, 32'd100);
    queue_sample(12'd3300, 1'b1, 1'b0, 32'd200);
    queue_sample(12'd1500, 1'b0, 1'b1, 32'd300);
    queue_sample(12'd1501, 1'b0, 1'b0, 32'd400);
    queue_sample(12'd1890, 1'b0, 1'b0, 32'd500);
    queue_sample(12'd1891, 1'b0, 1'b0, 32'd600);
    queue_sample(12'd2050, 1'b0, 1'b0, 32'd700);
    queue_sample(12'd2051, 1'b0, 1'b0, 32'd800);
    queue_sample(12'd1600, 1'b0, 1'b0, 32'd5800);
    queue_sample(12'd1600, 1'b0, 1'b0, 32'd5801);
    queue_sample(12'd1600, 1'b1, 1'b0, 32'd5802);
    queue_sample(12'd1600, 1'b0, 1'b0, 32'd5803);
    queue_sample(12'd1601, 1'b0, 1'b0, 32'd5804);
    queue_sample(12'd1700, 1'b0, 1'b0, 32'hFFFF_FFFF);
    queue_sample(12'd1000, 1'b0, 1'b0, 32'd5000);
    wait_drained();

    // unit ratio with junk upper bits, plus writes to unused indexes
    write_reg(CFG_DIVIDER_RATIO, 32'hFFFF_FFF1);
    write_reg(CFG_IDX_W'(4), 32'hFFFF_FFFF);
    write_reg(CFG_IDX_W'(255), 32'h0000_0000);
    @(negedge clk);
    queue_sample(12'd2999, 1'b0, 1'b0, 32'd5001);
    queue_sample(12'd3000, 1'b0, 1'b0, 32'd5002);
    queue_sample(12'd3001, 1'b0, 1'b1, 32'd5003);
    queue_sample(12'd4095, 1'b0, 1'b0, 32'd5004);
    queue_sample(12'd4094, 1'b1, 1'b1, 32'd5005);
    wait_drained();
    write_reg(CFG_SENSE_ENABLED, 32'hFFFF_FFFE);
    @(negedge clk);
    queue_sample(12'd4095, 1'b0, 1'b0, 32'd6000);

    for (phase = 0; phase < 8; phase++) begin
      wait_drained();
      repeat (4) @(posedge clk);
      case (phase)
        0: begin
          new_ratio = 4'd2; new_sense = 1'b1; new_low = 16'd3200; new_timeout = 32'd5000;
        end
        1: begin
          new_ratio = 4'd15; new_sense = 1'b1; new_low = 16'd49500; new_timeout = 32'd0;
        end
        2: begin
          new_ratio = 4'd0; new_sense = 1'b1; new_low = 16'd0; new_timeout = 32'hFFFF_FFFF;
        end
        3: begin
          new_ratio = 4'd1; new_sense = 1'b0; new_low = 16'd3200; new_timeout = 32'd100;
        end
        4: begin
          new_ratio = 4'd2; new_sense = 1'b1; new_low = 16'd3300; new_timeout = 32'd2000;
        end
        5: begin
          new_ratio = RATIO_W'($urandom_range(1, 15));
          new_sense = 1'b1;
          new_low = MV_W'($urandom_range(2500, 4200));
          new_timeout = $urandom_range(0, 20000);
        end
        6: begin
          new_ratio = 4'd3; new_sense = 1'b1; new_low = 16'hFFFF; new_timeout = 32'd1;
        end
        default: begin
          new_ratio = RATIO_W'($urandom);
          new_sense = 1'($urandom);
          new_low = MV_W'($urandom);
          new_timeout = $urandom;
        end
      endcase
      write_reg(CFG_LOW_TIMEOUT_TICKS, new_timeout);
      write_reg(CFG_LOW_VOLTAGE_MV, ($urandom << MV_W) | 32'(new_low));
      write_reg(CFG_SENSE_ENABLED, ($urandom << 1) | 32'(new_sense));
      write_reg(CFG_DIVIDER_RATIO, ($urandom << RATIO_W) | 32'(new_ratio));
      if ($urandom_range(0, 1) == 1) write_reg(CFG_IDX_W'($urandom_range(4, 255)), $urandom);
      calm <= (phase == 4);
      if ($urandom_range(0, 2) == 0) tick_now = 32'hFFFF_FFFF - $urandom_range(0, 20000);
      @(negedge clk);
      queue_phase(80);
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
